// ===== hw/rtl/vacr_pkg.sv =====
// Shared types, constants and arithmetic helpers for the voxel box collision resolver.
package vacr_pkg;

    localparam int FRAC_BITS = 8;
    // Internal length width: 32-bit position plus headroom for cube and face offsets
    localparam int LW = 34;

    localparam logic signed [LW-1:0] UNIT = LW'(1) << FRAC_BITS;
    localparam logic signed [LW-1:0] HALF = LW'(1) << (FRAC_BITS - 1);
    localparam logic [LW-1:0] FRAC_MASK = (LW'(1) << FRAC_BITS) - LW'(1);

    localparam logic signed [LW-1:0] S32_MAX = LW'(64'sh7FFF_FFFF);
    localparam logic signed [LW-1:0] S32_MIN = -(LW'(64'sh7FFF_FFFF)) - LW'(1);

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } t_axis;

    typedef enum logic [1:0] {
        CFG_HALF_XZ = 2'd0,
        CFG_HALF_Y  = 2'd1,
        CFG_FALL    = 2'd2,
        CFG_RESPAWN = 2'd3
    } t_cfg_idx;

    // One player tick in flight
    typedef struct packed {
        logic [2:0][31:0]   pos;
        logic [2:0][15:0]   vel;
        logic [2:0][LW-1:0] base;
        logic [26:0]        occ;
        logic               gnd;
    } t_item;

    // Clamp to the signed 32-bit range
    function automatic logic [31:0] sat32(input logic signed [LW-1:0] v);
        logic [31:0] r;
        if (v > S32_MAX) r = 32'h7FFF_FFFF;
        else if (v < S32_MIN) r = 32'h8000_0000;
        else r = v[31:0];
        return r;
    endfunction

    // Nearest whole unit, ties away from zero, scaled by one unit
    function automatic logic [LW-1:0] round_unit(input logic [31:0] p);
        logic signed [LW-1:0] a;
        logic [LW-1:0] m;
        a = {{(LW-32){p[31]}}, p};
        if (!p[31]) begin
            m = (a + HALF) & ~FRAC_MASK;
        end else begin
            m = -((-a + HALF) & ~FRAC_MASK);
        end
        return m;
    endfunction

endpackage

// ===== hw/rtl/vacr_axis.sv =====
// One axis of collision resolution: overlap test stage, then snap stage.
module vacr_axis (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  vacr_pkg::t_axis      i_axis,
    input  logic [7:0]           i_half_xz,
    input  logic [9:0]           i_half_y,
    input  logic                 i_valid,
    input  vacr_pkg::t_item      i_item,
    output logic                 o_valid,
    output vacr_pkg::t_item      o_item
);
    import vacr_pkg::*;

    logic        r_t_valid;
    t_item       r_t_item;
    logic [26:0] r_hit;
    logic [26:0] n_hit;
    logic        r_s_valid;
    t_item       r_s_item;
    t_item       n_s_item;

    // Test each axis against the three neighbor rows, then combine per cube
    always_comb begin
        logic [2:0][2:0] ov;
        logic signed [LW-1:0] p;
        logic signed [LW-1:0] h;
        logic signed [LW-1:0] c;
        for (int a = 0; a < 3; a++) begin
            p = {{(LW-32){i_item.pos[a][31]}}, i_item.pos[a]};
            h = (a == 1) ? LW'(i_half_y) : LW'(i_half_xz);
            for (int d = 0; d < 3; d++) begin
                c = $signed(i_item.base[a]) + LW'(d - 1) * UNIT;
                ov[a][d] = (p - h < c + HALF) && (p + h > c - HALF);
            end
        end
        for (int k = 0; k < 27; k++) begin
            n_hit[k] = i_item.occ[k] & ov[0][k/9] & ov[1][(k/3)%3] & ov[2][k%3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_valid <= 1'b0;
        end else if (i_en) begin
            r_t_valid <= i_valid;
        end
        if (i_en) begin
            r_t_item <= i_item;
            r_hit    <= n_hit;
        end
    end

    // Snap against the first hit cube, zero the velocity, move the next axis
    always_comb begin
        logic found;
        logic [1:0] d;
        logic [1:0] nx;
        logic signed [LW-1:0] c;
        logic signed [LW-1:0] h;
        logic signed [15:0] v;
        n_s_item = r_t_item;
        found = 1'b0;
        d = 2'd0;
        for (int k = 26; k >= 0; k--) begin
            if (r_hit[k]) begin
                found = 1'b1;
                unique case (i_axis)
                    AXIS_X:  d = 2'(k / 9);
                    AXIS_Y:  d = 2'((k / 3) % 3);
                    default: d = 2'(k % 3);
                endcase
            end
        end
        h = (i_axis == AXIS_Y) ? LW'(i_half_y) : LW'(i_half_xz);
        c = $signed(r_t_item.base[i_axis]) + LW'($signed({1'b0, d}) - 3'sd1) * UNIT;
        v = $signed(r_t_item.vel[i_axis]);
        if (found) begin
            if (v > 16'sd0) begin
                n_s_item.pos[i_axis] = sat32(c - HALF - h);
            end else if (v < 16'sd0) begin
                n_s_item.pos[i_axis] = sat32(c + HALF + h);
                if (i_axis == AXIS_Y) n_s_item.gnd = 1'b1;
            end
            n_s_item.vel[i_axis] = 16'd0;
        end
        nx = i_axis + 2'd1;
        if (i_axis != AXIS_Z) begin
            n_s_item.pos[nx] = sat32(
                $signed({{(LW-32){r_t_item.pos[nx][31]}}, r_t_item.pos[nx]})
                + $signed({{(LW-16){r_t_item.vel[nx][15]}}, r_t_item.vel[nx]}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else if (i_en) begin
            r_s_valid <= r_t_valid;
        end
        if (i_en) begin
            r_s_item <= n_s_item;
        end
    end

    assign o_valid = r_s_valid;
    assign o_item  = r_s_item;

endmodule

// ===== hw/rtl/voxel_aabb_collision_resolve.sv =====
// Top level of the voxel box collision resolver: config, input stage, three axes, respawn.
//
// Resolves one player tick per transaction. The pipeline takes a new transaction every
// cycle while the output is not stalled and passes it through eight register stages:
// one setup stage (rounding of the cube centres and the x move), two stages per axis
// (overlap test of all 27 cubes, then snap and the next axis move) and one output stage
// with the respawn check. A stall on the output freezes the whole pipeline; nothing is
// lost or repeated. Configuration writes take effect on the next cycle and are meant to
// happen while the pipeline is empty.
module voxel_aabb_collision_resolve (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // in_pos_x, in_pos_y, in_pos_z, in_vel_x, in_vel_y, in_vel_z, neighbor_occupancy, pad
    input  logic [175:0] s_axis_tdata,
    // grounded_in
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_pos_x, out_pos_y, out_pos_z, out_vel_x, out_vel_y, out_vel_z
    output logic [143:0] m_axis_tdata,
    // grounded_out
    output logic         m_axis_tuser
);
    import vacr_pkg::*;

    logic [7:0]  r_half_xz;
    logic [9:0]  r_half_y;
    logic [31:0] r_fall;
    logic [31:0] r_respawn;

    logic        en;
    logic        r_in_valid;
    t_item       r_in_item;
    t_item       n_in_item;
    logic        ax_valid_x, ax_valid_y, ax_valid_z;
    t_item       ax_item_x, ax_item_y, ax_item_z;
    logic        r_out_valid;
    t_item       r_out_item;
    t_item       n_out_item;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_xz <= 8'd64;
            r_half_y  <= 10'd224;
            r_fall    <= 32'hFFFF_F000;
            r_respawn <= 32'd23552;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_HALF_XZ: r_half_xz <= i_cfg_data[7:0];
                CFG_HALF_Y:  r_half_y  <= i_cfg_data[9:0];
                CFG_FALL:    r_fall    <= i_cfg_data;
                CFG_RESPAWN: r_respawn <= i_cfg_data;
            endcase
        end
    end

    // Advance the whole pipeline unless the output holds a result that is not taken
    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;

    // Unpack, round the cube centres, apply the x move
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_in_item.pos[a]  = s_axis_tdata[32*a +: 32];
            n_in_item.vel[a]  = s_axis_tdata[96 + 16*a +: 16];
            n_in_item.base[a] = round_unit(s_axis_tdata[32*a +: 32]);
        end
        n_in_item.occ = s_axis_tdata[170:144];
        n_in_item.gnd = s_axis_tuser;
        n_in_item.pos[0] = sat32(
            $signed({{(LW-32){s_axis_tdata[31]}}, s_axis_tdata[31:0]})
            + $signed({{(LW-16){s_axis_tdata[111]}}, s_axis_tdata[111:96]}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (en) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (en) begin
            r_in_item <= n_in_item;
        end
    end

    vacr_axis u_axis_x (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_axis    (AXIS_X),
        .i_half_xz (r_half_xz),
        .i_half_y  (r_half_y),
        .i_valid   (r_in_valid),
        .i_item    (r_in_item),
        .o_valid   (ax_valid_x),
        .o_item    (ax_item_x)
    );

    vacr_axis u_axis_y (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_axis    (AXIS_Y),
        .i_half_xz (r_half_xz),
        .i_half_y  (r_half_y),
        .i_valid   (ax_valid_x),
        .i_item    (ax_item_x),
        .o_valid   (ax_valid_y),
        .o_item    (ax_item_y)
    );

    vacr_axis u_axis_z (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_axis    (AXIS_Z),
        .i_half_xz (r_half_xz),
        .i_half_y  (r_half_y),
        .i_valid   (ax_valid_y),
        .i_item    (ax_item_y),
        .o_valid   (ax_valid_z),
        .o_item    (ax_item_z)
    );

    // Respawn below the fall limit
    always_comb begin
        n_out_item = ax_item_z;
        if ($signed(ax_item_z.pos[1]) < $signed(r_fall)) begin
            n_out_item.pos[1] = r_respawn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= ax_valid_z;
        end
        if (en) begin
            r_out_item <= n_out_item;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_item.vel, r_out_item.pos};
    assign m_axis_tuser  = r_out_item.gnd;

endmodule

// ===== tb/sv/tb_voxel_aabb_collision_resolve.sv =====
// Testbench for the voxel box collision resolver: directed and random ticks against a predictor.
`timescale 1ns / 1ps

module tb_voxel_aabb_collision_resolve;
    import vacr_pkg::*;

    typedef struct {
        logic signed [31:0] px, py, pz;
        logic signed [15:0] vx, vy, vz;
        logic               gnd;
    } t_tick_out;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [1:0]   i_cfg_idx;
    logic [31:0]  i_cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [175:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [143:0] m_axis_tdata;
    logic         m_axis_tuser;

    // Predictor copy of the registers
    longint cur_half_xz, cur_half_y, cur_fall, cur_respawn;

    t_tick_out resolved_q[$];
    int  src_idle_pct, dst_idle_pct;
    int  err_cnt;
    int  quiet_cycles;

    localparam int WATCHDOG = 20000;

    voxel_aabb_collision_resolve uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint nearest_unit(longint p);
        longint m;
        if (p >= 0) begin
            m = (p + 128) >>> 8;
            return m * 256;
        end
        m = (-p + 128) >>> 8;
        return -m * 256;
    endfunction

    // Resolve one tick: move and collide along x, y, z, then respawn check
    function automatic t_tick_out resolve_tick(logic [31:0] ipx, logic [31:0] ipy,
            logic [31:0] ipz, logic [15:0] ivx, logic [15:0] ivy, logic [15:0] ivz,
            logic [26:0] occ, logic gnd);
        longint p[3], v[3], base[3], h[3], c[3];
        bit hit;
        t_tick_out r;
        p[0] = longint'($signed(ipx)); p[1] = longint'($signed(ipy));
        p[2] = longint'($signed(ipz));
        v[0] = longint'($signed(ivx)); v[1] = longint'($signed(ivy));
        v[2] = longint'($signed(ivz));
        for (int a = 0; a < 3; a++) base[a] = nearest_unit(p[a]);
        h[0] = cur_half_xz; h[1] = cur_half_y; h[2] = cur_half_xz;
        for (int a = 0; a < 3; a++) begin
            p[a] = clamp32(p[a] + v[a]);
            for (int k = 0; k < 27; k++) begin
                if (!occ[k]) continue;
                c[0] = base[0] + (k / 9 - 1) * 256;
                c[1] = base[1] + ((k / 3) % 3 - 1) * 256;
                c[2] = base[2] + (k % 3 - 1) * 256;
                hit = 1;
                for (int b = 0; b < 3; b++)
                    if (!(p[b] - h[b] < c[b] + 128 && p[b] + h[b] > c[b] - 128)) hit = 0;
                if (!hit) continue;
                if (v[a] > 0) begin
                    p[a] = clamp32(c[a] - 128 - h[a]);
                end else if (v[a] < 0) begin
                    p[a] = clamp32(c[a] + 128 + h[a]);
                    if (a == 1) gnd = 1'b1;
                end
                v[a] = 0;
            end
        end
        if (p[1] < cur_fall) p[1] = cur_respawn;
        r.px = p[0][31:0]; r.py = p[1][31:0]; r.pz = p[2][31:0];
        r.vx = v[0][15:0]; r.vy = v[1][15:0]; r.vz = v[2][15:0];
        r.gnd = gnd;
        return r;
    endfunction

    // Send one tick and queue its expected resolution; valid stays high for a follower
    task automatic send_tick(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
            logic [15:0] vx, logic [15:0] vy, logic [15:0] vz, logic [26:0] occ, logic gnd);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, occ, vz, vy, vx, pz, py, px};
        s_axis_tuser  <= gnd;
        resolved_q = {resolved_q, resolve_tick(px, py, pz, vx, vy, vz, occ, gnd)};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Drop valid, wait for the pipeline to drain, then a few cycles more
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (resolved_q.size() != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        case (idx)
            CFG_HALF_XZ: cur_half_xz = longint'(val[7:0]);
            CFG_HALF_Y:  cur_half_y  = longint'(val[9:0]);
            CFG_FALL:    cur_fall    = longint'($signed(val));
            default:     cur_respawn = longint'($signed(val));
        endcase
    endtask

    // Random position: mostly near the origin, sometimes near the rails
    function automatic logic [31:0] rand_pos();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF - $urandom_range(1024);
            1: return 32'h8000_0000 + $urandom_range(1024);
            2: return $urandom();
            default: return $urandom_range(4096) - 2048;
        endcase
    endfunction

    function automatic logic [15:0] rand_vel();
        case ($urandom_range(7))
            0: return 16'd0;
            1: return 16'($urandom());
            default: return 16'($urandom_range(512) - 256);
        endcase
    endfunction

    task automatic test_directed();
        send_tick(0, 0, 0, 16'd0, 16'd0, 16'd0, 27'h7FF_FFFF, 1'b0);
        send_tick(0, 512, 0, 16'd0, -16'sd200, 16'd0, 27'h7FF_FFFF, 1'b0);
        send_tick(0, 0, 0, 16'sd100, 16'd0, 16'd0, 27'h7FF_FFFF, 1'b0);
        send_tick(0, 0, 0, -16'sd100, 16'sd100, -16'sd50, 27'h7FF_FFFF, 1'b1);
        send_tick(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  16'h7FFF, 16'h7FFF, 16'h7FFF, 27'h0, 1'b0);
        send_tick(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  16'h8000, 16'h8000, 16'h8000, 27'h0, 1'b0);
        send_tick(32'h7FFF_FF00, 32'h7FFF_FF00, 32'h7FFF_FF00,
                  16'h7FFF, 16'h7FFF, 16'h7FFF, 27'h7FF_FFFF, 1'b0);
        send_tick(32'h8000_0000, 32'h8000_0100, 32'h8000_0000,
                  16'h8000, 16'h8000, 16'h8000, 27'h7FF_FFFF, 1'b1);
        // Ties in rounding on both signs
        send_tick(128, -128, 384, 16'sd10, -16'sd10, 16'd0, 27'h155_5555, 1'b0);
        send_tick(-384, 640, -128, -16'sd10, 16'sd10, 16'sd5, 27'h2AA_AAAA, 1'b0);
        // Below and exactly at the fall limit
        send_tick(0, -32'sd5000, 0, 16'd0, -16'sd10, 16'd0, 27'h0, 1'b0);
        send_tick(0, -32'sd4096, 0, 16'd0, 16'd0, 16'd0, 27'h0, 1'b1);
        for (int k = 0; k < 27; k++)
            if (k % 3 == 0) send_tick(32, 60, -32, 16'sd40, -16'sd40, 16'sd40, 27'd1 << k, 1'b0);
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) begin
            send_tick(rand_pos(), rand_pos(), rand_pos(), rand_vel(), rand_vel(), rand_vel(),
                      ($urandom_range(3) == 0) ? 27'($urandom()) : 27'($urandom() | $urandom()),
                      1'($urandom()));
            // Hold off once, halfway through, until the pipeline empties
            if (i == n / 2) begin
                s_axis_tvalid <= 1'b0;
                @(negedge i_clk);
                while (resolved_q.size() != 0) @(negedge i_clk);
            end
        end
    endtask

    task automatic test_config_sweep();
        write_reg(CFG_HALF_XZ, 32'd0);
        write_reg(CFG_HALF_Y, 32'd1023);
        write_reg(CFG_FALL, 32'h8000_0000);
        write_reg(CFG_RESPAWN, 32'h7FFF_FFFF);
        test_random(100);
        drain();
        write_reg(CFG_HALF_XZ, 32'd255);
        write_reg(CFG_HALF_Y, 32'd0);
        write_reg(CFG_FALL, 32'h7FFF_FFFF);
        write_reg(CFG_RESPAWN, 32'h8000_0000);
        test_random(100);
        drain();
        write_reg(CFG_HALF_XZ, 32'($urandom_range(255)));
        write_reg(CFG_HALF_Y, 32'($urandom_range(1023)));
        write_reg(CFG_FALL, 32'($urandom_range(2000)) - 32'd3000);
        write_reg(CFG_RESPAWN, $urandom());
        test_random(100);
        drain();
    endtask

    // Receiver stalls
    always @(negedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);

    // Check each result and watch for a hang
    always @(posedge i_clk) begin
        t_tick_out e;
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG) begin
                $display("voxel_aabb_collision_resolve test failed");
                $finish;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (resolved_q.size() == 0) begin
                    $error("unexpected result tdata=%h", m_axis_tdata);
                    err_cnt++;
                end else begin
                    e = resolved_q.pop_front();
                    if (m_axis_tdata[31:0] !== e.px) begin
                        $error("out_pos_x exp %h got %h", e.px, m_axis_tdata[31:0]); err_cnt++;
                    end
                    if (m_axis_tdata[63:32] !== e.py) begin
                        $error("out_pos_y exp %h got %h", e.py, m_axis_tdata[63:32]); err_cnt++;
                    end
                    if (m_axis_tdata[95:64] !== e.pz) begin
                        $error("out_pos_z exp %h got %h", e.pz, m_axis_tdata[95:64]); err_cnt++;
                    end
                    if (m_axis_tdata[111:96] !== e.vx) begin
                        $error("out_vel_x exp %h got %h", e.vx, m_axis_tdata[111:96]); err_cnt++;
                    end
                    if (m_axis_tdata[127:112] !== e.vy) begin
                        $error("out_vel_y exp %h got %h", e.vy, m_axis_tdata[127:112]); err_cnt++;
                    end
                    if (m_axis_tdata[143:128] !== e.vz) begin
                        $error("out_vel_z exp %h got %h", e.vz, m_axis_tdata[143:128]); err_cnt++;
                    end
                    if (m_axis_tuser !== e.gnd) begin
                        $error("grounded_out exp %b got %b", e.gnd, m_axis_tuser); err_cnt++;
                    end
                end
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_HALF_XZ;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        err_cnt = 0;
        quiet_cycles = 0;
        src_idle_pct = 33;
        dst_idle_pct = 52;
        cur_half_xz = 64; cur_half_y = 224; cur_fall = -4096; cur_respawn = 23552;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_random(200);
        drain();
        src_idle_pct = 52;
        dst_idle_pct = 33;
        test_config_sweep();
        src_idle_pct = 0;
        dst_idle_pct = 0;
        write_reg(CFG_HALF_XZ, 32'd64);
        write_reg(CFG_HALF_Y, 32'd224);
        write_reg(CFG_FALL, -32'sd4096);
        write_reg(CFG_RESPAWN, 32'sd23552);
        test_random(360);
        drain();

        if (err_cnt == 0)
            $display("voxel_aabb_collision_resolve test passed");
        else
            $display("voxel_aabb_collision_resolve test failed");
        $finish;
    end

endmodule
